// ===== hdl/lpht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int TABLE_SIZE = 16;

  localparam int MODE_W   = 1;
  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_FOUND   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // home = (value / KEY_DIVISOR) * KEY_SCALE, by reciprocal multiply
  localparam int KEY_DIVISOR = 1000;
  localparam int KEY_SCALE   = 2;
  localparam int HASH_W      = 19;   // values below the home limit, largest table
  localparam int QUO_W       = 10;
  localparam int RECIP_SH    = 32;
  localparam int RECIP_W     = 23;
  localparam logic [RECIP_W-1:0] RECIP = 23'd4294967;  // floor(2^32 / 1000)

endpackage

// ===== hdl/lpht_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_if
// Valid/ready channels for requests and results of the hash table unit.
// ----------------------------------------------------------------------------
interface lpht_in_if;
  logic                        valid;
  logic                        ready;
  logic [lpht_pkg::MODE_W-1:0]  mode;
  logic [lpht_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface lpht_out_if;
  logic                         valid;
  logic                         ready;
  logic [lpht_pkg::STATUS_W-1:0] status;
  logic [lpht_pkg::POS_W-1:0]    position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

// ===== hdl/lpht_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/lpht_home.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_home
// Home slot unit: registered reciprocal multiply, then remainder correction.
// Result valid in the cycle after en.
// ----------------------------------------------------------------------------
module lpht_home #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE,
  localparam int IDX_W     = $clog2(TABLE_SIZE)
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [lpht_pkg::VALUE_W-1:0] value_i,
  output logic [IDX_W-1:0]             home_o
);

  localparam int PROD_W = lpht_pkg::HASH_W + lpht_pkg::RECIP_W;
  localparam int REM_W  = lpht_pkg::HASH_W + 1;
  localparam int H_W    = lpht_pkg::QUO_W + 1;
  localparam logic [lpht_pkg::VALUE_W-1:0] HOME_LIMIT =
    lpht_pkg::VALUE_W'(lpht_pkg::KEY_DIVISOR * ((TABLE_SIZE + 1) / 2));

  logic [PROD_W-1:0]           prod_r;
  logic [lpht_pkg::HASH_W-1:0] val_r;
  logic                        range_r;

  logic [lpht_pkg::QUO_W-1:0] quo0;
  logic [lpht_pkg::QUO_W-1:0] quo;
  logic [REM_W-1:0]           rem;
  logic [H_W-1:0]             home_full;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= PROD_W'(value_i[lpht_pkg::HASH_W-1:0]) * PROD_W'(lpht_pkg::RECIP);
      val_r   <= value_i[lpht_pkg::HASH_W-1:0];
      range_r <= (value_i < HOME_LIMIT);
    end
  end

  // quotient estimate is exact or one low
  always_comb begin
    quo0      = prod_r[lpht_pkg::RECIP_SH +: lpht_pkg::QUO_W];
    rem       = REM_W'(val_r) - REM_W'(quo0 * lpht_pkg::KEY_DIVISOR);
    quo       = quo0 + lpht_pkg::QUO_W'(rem >= REM_W'(lpht_pkg::KEY_DIVISOR));
    home_full = H_W'(quo) * H_W'(lpht_pkg::KEY_SCALE);
    home_o    = range_r ? home_full[IDX_W-1:0] : '0;
  end

endmodule

// ===== hdl/linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing; insert or search per
// request, one result per request.
//
//   channel  | dir | payload              | transfer
//   in_chan  | in  | mode, value          | valid && ready
//   out_chan | out | status, position     | valid && ready
//
// One request at a time: accept, find the home slot, then one slot read per
// cycle from the slot RAM; an insert into a full table goes straight to the
// result. The probe walk makes at most TABLE_SIZE + 1 reads (on search).
// After reset a clearing pass over all TABLE_SIZE slots empties the RAM; no
// request is taken meanwhile. A result waiting in the output register holds
// back only the next result, not the next request.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit #(
  parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE
) (
  input  logic       clk,
  input  logic       rst_n,
  lpht_in_if.sink    in_chan,
  lpht_out_if.source out_chan
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int CNT_W  = $clog2(TABLE_SIZE + 2);
  localparam int ENT_W  = $clog2(TABLE_SIZE + 1);
  localparam int WORD_W = lpht_pkg::VALUE_W + 1;
  localparam int POS_W  = lpht_pkg::POS_W;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HOME  = 6'b000100,
    S_PROBE = 6'b001000,
    S_DONE  = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [IDX_W-1:0]             clr_r, clr_nxt;
  logic                         mode_r, mode_nxt;
  logic [lpht_pkg::VALUE_W-1:0] value_r, value_nxt;
  logic [ENT_W-1:0]             count_r, count_nxt;
  logic [IDX_W-1:0]             rd_pos_r, rd_pos_nxt;
  logic [CNT_W-1:0]             rd_cnt_r, rd_cnt_nxt;
  logic                         chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]             chk_pos_r, chk_pos_nxt;
  lpht_pkg::status_t            res_status_r, res_status_nxt;
  logic [POS_W-1:0]             res_pos_r, res_pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  lpht_pkg::status_t            out_status_r, out_status_nxt;
  logic [POS_W-1:0]             out_pos_r, out_pos_nxt;

  logic                 in_xfer;
  logic                 issue;
  logic                 hit;
  logic                 last;
  logic [CNT_W-1:0]     limit;
  logic [IDX_W-1:0]     home;
  logic [IDX_W+POS_W-1:0] pos_ext;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic [WORD_W-1:0]    ram_rdata;

  assign in_chan.ready     = (state_r == S_IDLE);
  assign in_xfer           = in_chan.valid && in_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.position = out_pos_r;

  lpht_home #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_home (
    .clk     (clk),
    .en      (in_xfer),
    .value_i (in_chan.value),
    .home_o  (home)
  );

  lpht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (rd_pos_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    limit   = (mode_r == lpht_pkg::MODE_SEARCH) ? CNT_W'(TABLE_SIZE + 1)
                                                : CNT_W'(TABLE_SIZE);
    issue   = (state_r == S_PROBE) && (rd_cnt_r != limit);
    pos_ext = {{POS_W{1'b0}}, chk_pos_r};
    if (mode_r == lpht_pkg::MODE_SEARCH) begin
      hit = chk_vld_r && ram_rdata[WORD_W-1] &&
            (ram_rdata[lpht_pkg::VALUE_W-1:0] == value_r);
    end else begin
      hit = chk_vld_r && !ram_rdata[WORD_W-1];
    end
    last = chk_vld_r && (rd_cnt_r == limit);
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    mode_nxt       = mode_r;
    value_nxt      = value_r;
    count_nxt      = count_r;
    rd_pos_nxt     = rd_pos_r;
    rd_cnt_nxt     = rd_cnt_r;
    chk_vld_nxt    = 1'b0;
    chk_pos_nxt    = rd_pos_r;
    res_status_nxt = res_status_r;
    res_pos_nxt    = res_pos_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    ram_we         = 1'b0;
    ram_waddr      = clr_r;
    ram_wdata      = '0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(TABLE_SIZE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          mode_nxt  = in_chan.mode;
          value_nxt = in_chan.value;
          if ((in_chan.mode == lpht_pkg::MODE_INSERT) &&
              (count_r == ENT_W'(TABLE_SIZE))) begin
            res_status_nxt = lpht_pkg::ST_FULL;
            res_pos_nxt    = '0;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_HOME;
          end
        end
      end
      S_HOME: begin
        rd_pos_nxt = home;
        rd_cnt_nxt = '0;
        state_nxt  = S_PROBE;
      end
      S_PROBE: begin
        if (issue) begin
          rd_pos_nxt  = (rd_pos_r == IDX_W'(TABLE_SIZE - 1)) ? '0
                                                              : rd_pos_r + IDX_W'(1);
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
        end
        if (hit) begin
          chk_vld_nxt = 1'b0;
          res_pos_nxt = pos_ext[POS_W-1:0];
          state_nxt   = S_DONE;
          if (mode_r == lpht_pkg::MODE_INSERT) begin
            ram_we         = 1'b1;
            ram_waddr      = chk_pos_r;
            ram_wdata      = {1'b1, value_r};
            count_nxt      = count_r + ENT_W'(1);
            res_status_nxt = lpht_pkg::ST_STORED;
          end else begin
            res_status_nxt = lpht_pkg::ST_FOUND;
          end
        end else if (last) begin
          res_pos_nxt    = '0;
          res_status_nxt = (mode_r == lpht_pkg::MODE_SEARCH) ? lpht_pkg::ST_MISSING
                                                             : lpht_pkg::ST_FULL;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_pos_nxt    = res_pos_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    value_r      <= value_nxt;
    rd_pos_r     <= rd_pos_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    chk_pos_r    <= chk_pos_nxt;
    res_status_r <= res_status_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
  end

endmodule
